### rtl/gjm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gjm_pkg;

    // Default grid bounds
    localparam int ROWS_MAX_DEF = 32;
    localparam int COLS_MAX_DEF = 32;

    // Field widths
    localparam int JUMP_W    = 16;
    localparam int DIM_W     = 6;
    localparam int COUNT_W   = 6;
    localparam int COUNT_MAX = 63;
    localparam int DIM_RESET = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

    typedef struct packed {
        logic [JUMP_W-1:0] jump_len;
        logic              last_cell;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] min_cells;
        logic               reachable;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_ROW,
        ST_COLSET,
        ST_COL,
        ST_DRAIN,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic solve_init;
        logic cell_init;
        logic row_issue;
        logic col_init;
        logic col_issue;
        logic write_cell;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic j_zero;
        logic i_zero;
        logic dist_one;
        logic cell_last;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/grid_jump_min_moves.sv
`timescale 1ns / 1ps
`default_nettype none

// Fewest-cells path search over a jump grid. Cells arrive one request per
// cycle in row-major order while busy is low; each request carries a jump
// length (saturated to 63) and a last_cell mark. The request marked last_cell
// raises busy and starts the search over the configured rows by columns
// cells; cells loaded past the store depth are dropped. Each cell (i, j) is
// scanned along its row and then down its column through the single read
// port of each store, one entry per cycle. When the search ends, done is
// high for a single cycle with the answer on result, and the receiver
// cannot stall it: min_cells holds the count including the start, or 0 with
// reachable low when the bottom-right cell cannot be reached. Configuration
// writes are always taken (cfg_ready is tied high) and must only be made
// while busy is low; values are clamped to 1..ROWS_MAX and 1..COLS_MAX.
module grid_jump_min_moves #(
    parameter int ROWS_MAX = gjm_pkg::ROWS_MAX_DEF,
    parameter int COLS_MAX = gjm_pkg::COLS_MAX_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  gjm_pkg::in_item_t                      item,
    output logic                                   done,
    output gjm_pkg::out_item_t                     result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gjm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gjm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gjm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    gjm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_cell (item.last_cell),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    gjm_dp #(
        .ROWS_MAX (ROWS_MAX),
        .COLS_MAX (COLS_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

`ifndef SYNTHESIS
    // A result only appears while the search holds the block busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done raised while not busy");

    // The result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Reachable flag agrees with the count
    a_reach_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.reachable == (result.min_cells != '0)))
        else $error("reachable disagrees with min_cells");

    // A last cell starts the search
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last_cell) |=> busy)
        else $error("last cell did not start the search");
`endif

endmodule

`default_nettype wire

### rtl/gjm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module gjm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              last_cell,
    input  gjm_pkg::dp_status_t    status,
    output gjm_pkg::ctrl_cmd_t     cmd,
    output logic                   busy,
    output logic                   done
);
    import gjm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence load, per-cell scans and result
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_cell)
                    begin
                        cmd.solve_init = 1'b1;
                        state_next     = ST_CELL;
                    end
                end
            end
            ST_CELL:
            begin
                cmd.cell_init = 1'b1;
                state_next    = status.j_zero ? ST_COLSET : ST_ROW;
            end
            ST_ROW:
            begin
                cmd.row_issue = 1'b1;
                if (status.dist_one)
                begin
                    state_next = ST_COLSET;
                end
            end
            ST_COLSET:
            begin
                cmd.col_init = 1'b1;
                state_next   = status.i_zero ? ST_DRAIN : ST_COL;
            end
            ST_COL:
            begin
                cmd.col_issue = 1'b1;
                if (status.dist_one)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.write_cell = 1'b1;
                state_next     = status.cell_last ? ST_DONE : ST_CELL;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/gjm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module gjm_dp #(
    parameter int ROWS_MAX = gjm_pkg::ROWS_MAX_DEF,
    parameter int COLS_MAX = gjm_pkg::COLS_MAX_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  gjm_pkg::in_item_t                      item,
    input  gjm_pkg::ctrl_cmd_t                     cmd,
    output gjm_pkg::dp_status_t                    status,
    output gjm_pkg::out_item_t                     result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gjm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gjm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gjm_pkg::*;

    localparam int DEPTH  = ROWS_MAX * COLS_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LOAD_W = $clog2(DEPTH + 1);
    localparam int ROW_W  = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int COL_W  = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
    localparam int MAXW   = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int CMP_W  = ((MAXW > DIM_W) ? MAXW : DIM_W) + 1;

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(v) > hi)
        begin
            r = DIM_W'(hi);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Stores
    logic [COUNT_W-1:0] jump_mem  [DEPTH];
    logic [COUNT_W-1:0] steps_mem [DEPTH];

    logic [DIM_W-1:0]   rows_reg;
    logic [DIM_W-1:0]   cols_reg;
    logic [LOAD_W-1:0]  load_idx_reg;
    logic [ROW_W-1:0]   i_reg;
    logic [COL_W-1:0]   j_reg;
    logic [ADDR_W-1:0]  row_base_reg;
    logic [ADDR_W-1:0]  src_reg;
    logic [DIM_W-1:0]   dist_reg;
    logic               rd_valid_reg;
    logic [DIM_W-1:0]   rd_dist_reg;
    logic [COUNT_W-1:0] jump_rd_reg;
    logic [COUNT_W-1:0] steps_rd_reg;
    logic [COUNT_W-1:0] best_reg;
    logic               found_reg;
    logic [COUNT_W-1:0] final_reg;

    logic [COUNT_W-1:0] jump_sat;
    logic               load_room;
    logic               issue;
    logic               hit;
    logic               origin;
    logic               i_last;
    logic               j_last;
    logic [ADDR_W-1:0]  here;
    logic [ADDR_W-1:0]  cols_ext;
    logic [COUNT_W-1:0] wval;

    assign cfg_ready = 1'b1;

    // Write configuration, clamped to the grid bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= clamp_dim(DIM_W'(DIM_RESET), ROWS_MAX);
            cols_reg <= clamp_dim(DIM_W'(DIM_RESET), COLS_MAX);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_ROWS)
            begin
                rows_reg <= clamp_dim(cfg_data, ROWS_MAX);
            end
            else if (cfg_index == REG_COLS)
            begin
                cols_reg <= clamp_dim(cfg_data, COLS_MAX);
            end
        end
    end

    // Saturate the jump length and check store room
    assign jump_sat  = (item.jump_len > JUMP_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                            : item.jump_len[COUNT_W-1:0];
    assign load_room = load_idx_reg < LOAD_W'(DEPTH);

    // Advance the load index; drop cells once the store is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (item.last_cell)
            begin
                load_idx_reg <= '0;
            end
            else if (load_room)
            begin
                load_idx_reg <= load_idx_reg + LOAD_W'(1);
            end
        end
    end

    // Jump store: written at load, read during scans
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_room)
        begin
            jump_mem[load_idx_reg[ADDR_W-1:0]] <= jump_sat;
        end
    end

    assign issue = cmd.row_issue | cmd.col_issue;

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            jump_rd_reg <= jump_mem[src_reg];
        end
    end

    // Steps store: written once per cell, read during scans
    always_ff @(posedge clk)
    begin
        if (cmd.write_cell)
        begin
            steps_mem[here] <= wval;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            steps_rd_reg <= steps_mem[src_reg];
        end
    end

    // Cell position and address bookkeeping
    assign cols_ext = ADDR_W'(cols_reg);
    assign here     = row_base_reg + ADDR_W'(j_reg);
    assign i_last   = (CMP_W'(i_reg) + CMP_W'(1)) == CMP_W'(rows_reg);
    assign j_last   = (CMP_W'(j_reg) + CMP_W'(1)) == CMP_W'(cols_reg);
    assign origin   = (i_reg == '0) && (j_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg        <= '0;
            j_reg        <= '0;
            row_base_reg <= '0;
        end
        else if (cmd.solve_init)
        begin
            i_reg        <= '0;
            j_reg        <= '0;
            row_base_reg <= '0;
        end
        else if (cmd.write_cell)
        begin
            if (j_last)
            begin
                j_reg        <= '0;
                i_reg        <= i_reg + ROW_W'(1);
                row_base_reg <= row_base_reg + cols_ext;
            end
            else
            begin
                j_reg <= j_reg + COL_W'(1);
            end
        end
    end

    // Walk the scan source along the row, then down the column
    always_ff @(posedge clk)
    begin
        if (cmd.cell_init)
        begin
            src_reg  <= row_base_reg;
            dist_reg <= DIM_W'(j_reg);
        end
        else if (cmd.col_init)
        begin
            src_reg  <= ADDR_W'(j_reg);
            dist_reg <= DIM_W'(i_reg);
        end
        else if (cmd.row_issue)
        begin
            src_reg  <= src_reg + ADDR_W'(1);
            dist_reg <= dist_reg - DIM_W'(1);
        end
        else if (cmd.col_issue)
        begin
            src_reg  <= src_reg + cols_ext;
            dist_reg <= dist_reg - DIM_W'(1);
        end
    end

    // Track which read returns this cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_dist_reg <= dist_reg;
        end
    end

    // Keep the least count among sources that reach this cell
    assign hit = rd_valid_reg && (steps_rd_reg != '0) && (rd_dist_reg <= jump_rd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.cell_init)
        begin
            found_reg <= 1'b0;
            best_reg  <= '0;
        end
        else if (hit)
        begin
            found_reg <= 1'b1;
            if (!found_reg || (steps_rd_reg < best_reg))
            begin
                best_reg <= steps_rd_reg;
            end
        end
    end

    // Form the cell count, saturating long paths
    always_comb
    begin
        if (origin)
        begin
            wval = COUNT_W'(1);
        end
        else if (!found_reg)
        begin
            wval = '0;
        end
        else if (best_reg == COUNT_W'(COUNT_MAX))
        begin
            wval = best_reg;
        end
        else
        begin
            wval = best_reg + COUNT_W'(1);
        end
    end

    // Hold the count of the most recent cell; the last one is the answer
    always_ff @(posedge clk)
    begin
        if (cmd.write_cell)
        begin
            final_reg <= wval;
        end
    end

    assign result.min_cells = final_reg;
    assign result.reachable = final_reg != '0;

    assign status.j_zero    = j_reg == '0;
    assign status.i_zero    = i_reg == '0;
    assign status.dist_one  = dist_reg == DIM_W'(1);
    assign status.cell_last = i_last && j_last;

endmodule

`default_nettype wire
